// ===== rtl/ppts_pkg.sv =====
package ppts_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int CLASS_COUNT_DEF = 6;
  localparam int MAX_QUANTUM_DEF = 64;

  // operation codes
  localparam logic [2:0] OP_ALLOC     = 3'd0;
  localparam logic [2:0] OP_FREE      = 3'd1;
  localparam logic [2:0] OP_SET_STATE = 3'd2;
  localparam logic [2:0] OP_TICK      = 3'd3;
  localparam logic [2:0] OP_PICK      = 3'd4;
  localparam logic [2:0] OP_SET_CLASS = 3'd5;
  localparam logic [2:0] OP_SET_QUANT = 3'd6;
  localparam logic [2:0] OP_QUERY     = 3'd7;

  // life states
  localparam logic [2:0] LS_UNUSED   = 3'd0;
  localparam logic [2:0] LS_USED     = 3'd1;
  localparam logic [2:0] LS_SLEEPING = 3'd2;
  localparam logic [2:0] LS_RUNNABLE = 3'd3;
  localparam logic [2:0] LS_RUNNING  = 3'd4;
  localparam logic [2:0] LS_ZOMBIE   = 3'd5;

  // classes
  localparam logic [2:0] CL_INTERACTIVE = 3'd0;
  localparam logic [2:0] CL_IO_BOUND    = 3'd1;
  localparam logic [2:0] CL_NORMAL      = 3'd2;
  localparam logic [2:0] CL_CPU_BOUND   = 3'd3;
  localparam logic [2:0] CL_BATCH       = 3'd4;
  localparam logic [2:0] CL_SYSTEM      = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_BAD_ARG = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_DEF_PRIO    = 3'd0;
  localparam logic [2:0] CFG_Q_INTERACT  = 3'd1;
  localparam logic [2:0] CFG_Q_IO_BOUND  = 3'd2;
  localparam logic [2:0] CFG_Q_NORMAL    = 3'd3;
  localparam logic [2:0] CFG_Q_CPU_BOUND = 3'd4;
  localparam logic [2:0] CFG_Q_BATCH     = 3'd5;
  localparam logic [2:0] CFG_Q_SYSTEM    = 3'd6;

  typedef struct packed {
    logic [4:0] default_priority;
    logic [6:0] q_interactive;
    logic [6:0] q_io_bound;
    logic [6:0] q_normal;
    logic [6:0] q_cpu_bound;
    logic [6:0] q_batch;
    logic [6:0] q_system;
  } cfg_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [2:0]  life;
    logic [15:0] id;
    logic [15:0] parent;
    logic [4:0]  prio;
    logic [2:0]  cls;
    logic [6:0]  quantum;
    logic [31:0] slice;
    logic [31:0] ready;
    logic [31:0] run;
    logic [31:0] sleep;
    logic [31:0] switches;
    logic [31:0] birth;
  } row_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
    logic [15:0] parent;
    logic [2:0]  state;
    logic [4:0]  prio;
    logic [2:0]  cls;
    logic [6:0]  quantum;
    logic [31:0] ready;
    logic [31:0] run;
    logic [31:0] sleep;
    logic [31:0] switches;
    logic [31:0] lifetime;
  } res_t;

  function automatic logic [6:0] class_quantum(cfg_t c, logic [2:0] k);
    logic [6:0] q;
    case (k)
      CL_INTERACTIVE: q = c.q_interactive;
      CL_IO_BOUND:    q = c.q_io_bound;
      CL_CPU_BOUND:   q = c.q_cpu_bound;
      CL_BATCH:       q = c.q_batch;
      CL_SYSTEM:      q = c.q_system;
      default:        q = c.q_normal;
    endcase
    return q;
  endfunction

endpackage

// ===== rtl/ppts_ram.sv =====
module ppts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ppts_ctrl.sv =====
module ppts_ctrl
  import ppts_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int CLASS_COUNT = CLASS_COUNT_DEF,
  parameter int MAX_QUANTUM = MAX_QUANTUM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [15:0] tid,
  input  logic [15:0] pid,
  input  logic [2:0]  nst,
  input  logic [2:0]  cls,
  input  logic [6:0]  qv,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        res
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int RW = $bits(row_t);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_FIN, S_DONE} state_t;

  state_t           state_r;
  logic [2:0]       op_r;
  logic [15:0]      tid_r, pid_r;
  logic [2:0]       nst_r, cls_r;
  logic [6:0]       qv_r;
  logic [IW-1:0]    idx_r;
  logic             hit_r, free_r, par_r;
  logic [IW-1:0]    hit_idx_r, free_idx_r;
  row_t             hit_row_r, par_row_r;
  logic [31:0]      tick_now_r;
  logic [15:0]      next_id_r;
  logic [TABLE_SLOTS-1:0] valid_r;
  res_t             res_r, out_r;
  logic             out_valid_r;

  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr;
  row_t             ram_wdata;
  logic [RW-1:0]    ram_rdata;
  row_t             row;
  logic             live, last;
  logic             bad_arg;
  res_t             bad_res;
  res_t             fin_res;
  logic             out_free;

  ppts_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // entry never written reads as unused
  always_comb begin
    row  = valid_r[idx_r] ? row_t'(ram_rdata) : '0;
    live = (row.life != LS_UNUSED);
    last = (idx_r == IW'(TABLE_SLOTS - 1));
  end

  // argument checks done before any lookup
  always_comb begin
    bad_res        = '0;
    bad_res.status = STAT_BAD_ARG;
    case (op)
      OP_SET_STATE: bad_arg = (nst > LS_ZOMBIE);
      OP_SET_CLASS: bad_arg = ({1'b0, cls} >= 4'(CLASS_COUNT));
      OP_SET_QUANT: bad_arg = (qv == 7'd0) || (qv > 7'(MAX_QUANTUM));
      default:      bad_arg = 1'b0;
    endcase
  end

  // memory write and final result
  always_comb begin
    ram_re    = (state_r == S_RD);
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = row;
    fin_res   = '0;
    if (state_r == S_EV && op_r == OP_TICK) begin
      ram_we = 1'b1;
      case (row.life)
        LS_RUNNABLE: ram_wdata.ready = row.ready + 32'd1;
        LS_RUNNING: begin
          ram_wdata.run   = row.run + 32'd1;
          ram_wdata.slice = row.slice + 32'd1;
        end
        LS_SLEEPING: ram_wdata.sleep = row.sleep + 32'd1;
        default: ram_we = 1'b0;
      endcase
    end else if (state_r == S_FIN) begin
      ram_waddr = hit_idx_r;
      ram_wdata = hit_row_r;
      case (op_r)
        OP_ALLOC: begin
          if (!free_r) begin
            fin_res.status = STAT_MISSING;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_r;
            ram_wdata = '0;
            ram_wdata.life  = LS_USED;
            ram_wdata.id    = next_id_r;
            ram_wdata.birth = tick_now_r;
            if (par_r) begin
              ram_wdata.parent  = pid_r;
              ram_wdata.prio    = par_row_r.prio;
              ram_wdata.cls     = par_row_r.cls;
              ram_wdata.quantum = par_row_r.quantum;
            end else begin
              ram_wdata.prio    = cfg.default_priority;
              ram_wdata.cls     = CL_NORMAL;
              ram_wdata.quantum = cfg.q_normal;
            end
            fin_res.id = next_id_r;
          end
        end
        OP_TICK: fin_res = '0;
        OP_PICK: begin
          if (!hit_r) begin
            fin_res.status = STAT_MISSING;
          end else begin
            ram_we = 1'b1;
            ram_wdata.life     = LS_RUNNING;
            ram_wdata.slice    = '0;
            ram_wdata.switches = hit_row_r.switches + 32'd1;
            fin_res.id = hit_row_r.id;
          end
        end
        default: begin
          if (!hit_r) begin
            fin_res.status = STAT_MISSING;
          end else begin
            case (op_r)
              OP_FREE: begin
                ram_we = 1'b1;
                ram_wdata.life = LS_UNUSED;
              end
              OP_SET_STATE: begin
                ram_we = 1'b1;
                ram_wdata.life = nst_r;
              end
              OP_SET_CLASS: begin
                ram_we = 1'b1;
                ram_wdata.cls     = cls_r;
                ram_wdata.quantum = class_quantum(cfg, cls_r);
              end
              OP_SET_QUANT: begin
                ram_we = 1'b1;
                ram_wdata.quantum = qv_r;
              end
              default: begin
                fin_res.id       = hit_row_r.id;
                fin_res.parent   = hit_row_r.parent;
                fin_res.state    = hit_row_r.life;
                fin_res.prio     = hit_row_r.prio;
                fin_res.cls      = hit_row_r.cls;
                fin_res.quantum  = hit_row_r.quantum;
                fin_res.ready    = hit_row_r.ready;
                fin_res.run      = hit_row_r.run;
                fin_res.sleep    = hit_row_r.sleep;
                fin_res.switches = hit_row_r.switches;
                fin_res.lifetime = tick_now_r - hit_row_r.birth;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign res       = out_r;

  // sequencer: scan the table slot by slot (S_RD then S_EV for each slot), then commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      tick_now_r  <= '0;
      next_id_r   <= 16'd1;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      // load a new result or drop the taken one
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= op;
            tid_r <= tid;
            pid_r <= pid;
            nst_r <= nst;
            cls_r <= cls;
            qv_r  <= qv;
            idx_r <= '0;
            hit_r <= 1'b0;
            free_r <= 1'b0;
            par_r <= 1'b0;
            if (op == OP_TICK) begin
              tick_now_r <= tick_now_r + 32'd1;
            end
            if (bad_arg) begin
              res_r   <= bad_res;
              state_r <= S_DONE;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: begin
          case (op_r)
            OP_ALLOC: begin
              if (!live && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= idx_r;
              end
              if (live && pid_r != 16'd0 && row.id == pid_r && !par_r) begin
                par_r     <= 1'b1;
                par_row_r <= row;
              end
            end
            OP_TICK: hit_r <= 1'b0;
            OP_PICK: begin
              if (row.life == LS_RUNNABLE &&
                  (!hit_r || row.prio < hit_row_r.prio)) begin
                hit_r     <= 1'b1;
                hit_idx_r <= idx_r;
                hit_row_r <= row;
              end
            end
            default: begin
              if (live && tid_r != 16'd0 && row.id == tid_r && !hit_r) begin
                hit_r     <= 1'b1;
                hit_idx_r <= idx_r;
                hit_row_r <= row;
              end
            end
          endcase
          if (last) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + IW'(1);
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          res_r <= fin_res;
          if (op_r == OP_ALLOC && free_r) begin
            valid_r[free_idx_r] <= 1'b1;
            next_id_r <= (next_id_r == 16'hFFFF) ? 16'd1 : next_id_r + 16'd1;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/priority_process_table_scheduler.sv =====
// Process table scheduler: entries live in one synchronous memory row each;
// every operation that passes its range check scans all TABLE_SLOTS rows
// through the single read port, a read state then an evaluate state per
// slot, then commits at most one row write; arguments that fail their range
// check skip the scan. Ticks update each affected row during the scan. The
// result sits in an output register, so the next transaction is taken while
// it waits. Configuration writes apply on the next cycle.
module priority_process_table_scheduler
  import ppts_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int CLASS_COUNT = CLASS_COUNT_DEF,
  parameter int MAX_QUANTUM = MAX_QUANTUM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_target_id,
  input  logic [15:0] in_parent_id,
  input  logic [2:0]  in_new_state,
  input  logic [2:0]  in_class_value,
  input  logic [6:0]  in_quantum_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_result_id,
  output logic [15:0] out_result_parent,
  output logic [2:0]  out_result_state,
  output logic [4:0]  out_result_priority,
  output logic [2:0]  out_result_class,
  output logic [6:0]  out_result_quantum,
  output logic [31:0] out_result_ready,
  output logic [31:0] out_result_run,
  output logic [31:0] out_result_sleep,
  output logic [31:0] out_result_switches,
  output logic [31:0] out_result_lifetime
);

  cfg_t cfg_r;
  res_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_priority <= 5'd10;
      cfg_r.q_interactive    <= 7'd1;
      cfg_r.q_io_bound       <= 7'd1;
      cfg_r.q_normal         <= 7'd1;
      cfg_r.q_cpu_bound      <= 7'd4;
      cfg_r.q_batch          <= 7'd8;
      cfg_r.q_system         <= 7'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEF_PRIO:    cfg_r.default_priority <= cfg_data[4:0];
        CFG_Q_INTERACT:  cfg_r.q_interactive <= cfg_data;
        CFG_Q_IO_BOUND:  cfg_r.q_io_bound <= cfg_data;
        CFG_Q_NORMAL:    cfg_r.q_normal <= cfg_data;
        CFG_Q_CPU_BOUND: cfg_r.q_cpu_bound <= cfg_data;
        CFG_Q_BATCH:     cfg_r.q_batch <= cfg_data;
        CFG_Q_SYSTEM:    cfg_r.q_system <= cfg_data;
        default: ;
      endcase
    end
  end

  ppts_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .CLASS_COUNT (CLASS_COUNT),
    .MAX_QUANTUM (MAX_QUANTUM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (in_operation),
    .tid       (in_target_id),
    .pid       (in_parent_id),
    .nst       (in_new_state),
    .cls       (in_class_value),
    .qv        (in_quantum_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_status          = res.status;
  assign out_result_id       = res.id;
  assign out_result_parent   = res.parent;
  assign out_result_state    = res.state;
  assign out_result_priority = res.prio;
  assign out_result_class    = res.cls;
  assign out_result_quantum  = res.quantum;
  assign out_result_ready    = res.ready;
  assign out_result_run      = res.run;
  assign out_result_sleep    = res.sleep;
  assign out_result_switches = res.switches;
  assign out_result_lifetime = res.lifetime;

endmodule

// ===== bench/priority_process_table_scheduler_tb.sv =====
module priority_process_table_scheduler_tb;
  import ppts_pkg::*;

  localparam int SLOTS = 64;
  localparam int CLASSES = 6;
  localparam int QUANT_MAX = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int ITEM_CYCLES = 2 * SLOTS + 3;

  // Process table model and store of expected replies
  class sched_scoreboard;
    logic [2:0]  life[SLOTS];
    logic [15:0] pid_of[SLOTS];
    logic [15:0] parent_of[SLOTS];
    logic [4:0]  prio_of[SLOTS];
    logic [2:0]  class_of[SLOTS];
    logic [6:0]  quant_of[SLOTS];
    logic [31:0] slice_of[SLOTS];
    logic [31:0] ready_of[SLOTS];
    logic [31:0] run_of[SLOTS];
    logic [31:0] sleep_of[SLOTS];
    logic [31:0] switch_of[SLOTS];
    logic [31:0] born_at[SLOTS];
    logic [15:0] id_counter;
    logic [31:0] tick_count;
    logic [6:0]  regs[7];
    res_t        expected_replies[$];
    int          mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) life[i] = LS_UNUSED;
      id_counter = 16'd1;
      tick_count = 0;
      regs[CFG_DEF_PRIO] = 7'd10;
      regs[CFG_Q_INTERACT] = 7'd1;
      regs[CFG_Q_IO_BOUND] = 7'd1;
      regs[CFG_Q_NORMAL] = 7'd1;
      regs[CFG_Q_CPU_BOUND] = 7'd4;
      regs[CFG_Q_BATCH] = 7'd8;
      regs[CFG_Q_SYSTEM] = 7'd2;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [6:0] data);
      regs[idx] = (idx == CFG_DEF_PRIO) ? {2'b00, data[4:0]} : data;
    endfunction

    function int find_slot(logic [15:0] id);
      if (id == 16'd0) return -1;
      for (int i = 0; i < SLOTS; i++)
        if (life[i] != LS_UNUSED && pid_of[i] == id) return i;
      return -1;
    endfunction

    function logic [6:0] quantum_for(logic [2:0] c);
      case (c)
        CL_INTERACTIVE: return regs[CFG_Q_INTERACT];
        CL_IO_BOUND:    return regs[CFG_Q_IO_BOUND];
        CL_CPU_BOUND:   return regs[CFG_Q_CPU_BOUND];
        CL_BATCH:       return regs[CFG_Q_BATCH];
        CL_SYSTEM:      return regs[CFG_Q_SYSTEM];
        default:        return regs[CFG_Q_NORMAL];
      endcase
    endfunction

    // Random live id, or 0 when the table is empty
    function logic [15:0] any_live_id();
      logic [15:0] ids[$];
      for (int i = 0; i < SLOTS; i++)
        if (life[i] != LS_UNUSED) ids.push_back(pid_of[i]);
      if (ids.size() == 0) return 16'd0;
      return ids[$urandom_range(ids.size() - 1)];
    endfunction

    // Update the table for one accepted transaction and queue its reply
    function void note_request(logic [2:0] op, logic [15:0] tid, logic [15:0] prt,
                               logic [2:0] nst, logic [2:0] cv, logic [6:0] qv);
      res_t r;
      int s;
      int p;
      r = '0;
      s = -1;
      case (op)
        OP_ALLOC: begin
          for (int i = 0; i < SLOTS; i++)
            if (s < 0 && life[i] == LS_UNUSED) s = i;
          if (s < 0) r.status = STAT_MISSING;
          else begin
            p = find_slot(prt);
            if (p >= 0) begin
              parent_of[s] = prt;
              prio_of[s] = prio_of[p];
              class_of[s] = class_of[p];
              quant_of[s] = quant_of[p];
            end else begin
              parent_of[s] = 16'd0;
              prio_of[s] = regs[CFG_DEF_PRIO][4:0];
              class_of[s] = CL_NORMAL;
              quant_of[s] = regs[CFG_Q_NORMAL];
            end
            pid_of[s] = id_counter;
            id_counter = (id_counter == 16'hFFFF) ? 16'd1 : id_counter + 16'd1;
            life[s] = LS_USED;
            slice_of[s] = 0;
            ready_of[s] = 0;
            run_of[s] = 0;
            sleep_of[s] = 0;
            switch_of[s] = 0;
            born_at[s] = tick_count;
            r.id = pid_of[s];
          end
        end
        OP_FREE: begin
          s = find_slot(tid);
          if (s < 0) r.status = STAT_MISSING;
          else life[s] = LS_UNUSED;
        end
        OP_SET_STATE: begin
          if (nst > LS_ZOMBIE) r.status = STAT_BAD_ARG;
          else begin
            s = find_slot(tid);
            if (s < 0) r.status = STAT_MISSING;
            else life[s] = nst;
          end
        end
        OP_TICK: begin
          tick_count++;
          for (int i = 0; i < SLOTS; i++) begin
            if (life[i] == LS_RUNNABLE) ready_of[i]++;
            else if (life[i] == LS_RUNNING) begin
              run_of[i]++;
              slice_of[i]++;
            end else if (life[i] == LS_SLEEPING) sleep_of[i]++;
          end
        end
        OP_PICK: begin
          for (int i = 0; i < SLOTS; i++)
            if (life[i] == LS_RUNNABLE && (s < 0 || prio_of[i] < prio_of[s])) s = i;
          if (s < 0) r.status = STAT_MISSING;
          else begin
            life[s] = LS_RUNNING;
            slice_of[s] = 0;
            switch_of[s]++;
            r.id = pid_of[s];
          end
        end
        OP_SET_CLASS: begin
          if (cv >= CLASSES) r.status = STAT_BAD_ARG;
          else begin
            s = find_slot(tid);
            if (s < 0) r.status = STAT_MISSING;
            else begin
              class_of[s] = cv;
              quant_of[s] = quantum_for(cv);
            end
          end
        end
        OP_SET_QUANT: begin
          if (qv < 1 || qv > QUANT_MAX) r.status = STAT_BAD_ARG;
          else begin
            s = find_slot(tid);
            if (s < 0) r.status = STAT_MISSING;
            else quant_of[s] = qv;
          end
        end
        default: begin
          s = find_slot(tid);
          if (s < 0) r.status = STAT_MISSING;
          else begin
            r.id = pid_of[s];
            r.parent = parent_of[s];
            r.state = life[s];
            r.prio = prio_of[s];
            r.cls = class_of[s];
            r.quantum = quant_of[s];
            r.ready = ready_of[s];
            r.run = run_of[s];
            r.sleep = sleep_of[s];
            r.switches = switch_of[s];
            r.lifetime = tick_count - born_at[s];
          end
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, exp_v, got_v);
    endfunction

    // Compare one reply with the oldest expectation
    function void check_result(res_t got);
      res_t e;
      if (expected_replies.size() == 0) begin
        report("unexpected reply, status", 0, got.status);
        return;
      end
      e = expected_replies.pop_front();
      if (got.status !== e.status) report("status", e.status, got.status);
      if (got.id !== e.id) report("id", e.id, got.id);
      if (got.parent !== e.parent) report("parent", e.parent, got.parent);
      if (got.state !== e.state) report("state", e.state, got.state);
      if (got.prio !== e.prio) report("priority", e.prio, got.prio);
      if (got.cls !== e.cls) report("class", e.cls, got.cls);
      if (got.quantum !== e.quantum) report("quantum", e.quantum, got.quantum);
      if (got.ready !== e.ready) report("ready", e.ready, got.ready);
      if (got.run !== e.run) report("run", e.run, got.run);
      if (got.sleep !== e.sleep) report("sleep", e.sleep, got.sleep);
      if (got.switches !== e.switches) report("switches", e.switches, got.switches);
      if (got.lifetime !== e.lifetime) report("lifetime", e.lifetime, got.lifetime);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_DEF_PRIO;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = OP_TICK;
  logic [15:0] in_target_id = '0;
  logic [15:0] in_parent_id = '0;
  logic [2:0]  in_new_state = LS_UNUSED;
  logic [2:0]  in_class_value = CL_INTERACTIVE;
  logic [6:0]  in_quantum_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  res_t        reply;

  sched_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;

  priority_process_table_scheduler i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_target_id        (in_target_id),
    .in_parent_id        (in_parent_id),
    .in_new_state        (in_new_state),
    .in_class_value      (in_class_value),
    .in_quantum_value    (in_quantum_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (reply.status),
    .out_result_id       (reply.id),
    .out_result_parent   (reply.parent),
    .out_result_state    (reply.state),
    .out_result_priority (reply.prio),
    .out_result_class    (reply.cls),
    .out_result_quantum  (reply.quantum),
    .out_result_ready    (reply.ready),
    .out_result_run      (reply.run),
    .out_result_sleep    (reply.sleep),
    .out_result_switches (reply.switches),
    .out_result_lifetime (reply.lifetime)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every reply taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(reply);
  end

  // Receiver stall pattern: changing modes, including long stretches of no stall
  always @(negedge clk) begin
    int mode;
    mode = int'(($time / 20000) % 4);
    case (mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      2: out_stall <= ((($time / 10) % 16) < 9);
      default: out_stall <= ($urandom_range(1) == 0);
    endcase
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("priority_process_table_scheduler regression: fail");
      $finish;
    end
  end

  // Drive one transaction, holding it until the block takes it
  task automatic send_item(logic [2:0] op, logic [15:0] tid, logic [15:0] prt,
                           logic [2:0] nst, logic [2:0] cv, logic [6:0] qv);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(3) == 0 ? 0 : $urandom_range(12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_operation = op;
    in_target_id = tid;
    in_parent_id = prt;
    in_new_state = nst;
    in_class_value = cv;
    in_quantum_value = qv;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(op, tid, prt, nst, cv, qv);
  endtask

  // Wait for every reply, let the block settle, then rewrite all registers
  task automatic reconfigure(int mode);
    logic [6:0] v;
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (ITEM_CYCLES + 20) @(posedge clk);
    for (int r = CFG_DEF_PRIO; r <= CFG_Q_SYSTEM; r++) begin
      if (r == CFG_DEF_PRIO)
        v = (mode == 0) ? 7'd0 : (mode == 1) ? 7'd20 : 7'($urandom_range(20));
      else
        v = (mode == 0) ? 7'd1 : (mode == 1) ? 7'd64 : 7'($urandom_range(1, 64));
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = 3'(r);
      cfg_data = v;
      sb.write_reg(3'(r), v);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random transaction, mostly aimed at live entries
  task automatic random_item(bit fill);
    logic [2:0] op;
    logic [15:0] tid;
    logic [15:0] prt;
    logic [2:0] nst;
    logic [2:0] cv;
    logic [6:0] qv;
    int w;
    w = $urandom_range(99);
    if (fill || w < 14) op = OP_ALLOC;
    else if (w < 20) op = OP_FREE;
    else if (w < 40) op = OP_SET_STATE;
    else if (w < 55) op = OP_TICK;
    else if (w < 67) op = OP_PICK;
    else if (w < 75) op = OP_SET_CLASS;
    else if (w < 83) op = OP_SET_QUANT;
    else op = OP_QUERY;
    tid = ($urandom_range(9) < 8) ? sb.any_live_id() : 16'($urandom);
    w = $urandom_range(9);
    prt = (w < 7) ? sb.any_live_id() : (w < 8) ? 16'd0 : 16'($urandom);
    nst = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
    if ($urandom_range(9) < 5) nst = LS_RUNNABLE;
    cv = ($urandom_range(7) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
    qv = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
    send_item(op, tid, prt, nst, cv, qv);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, allocation paths, range checks, tie on pick
    send_item(OP_QUERY, 16'd1, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_FREE, 16'd5, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_PICK, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7, 7'h7F);
    send_item(OP_ALLOC, 16'd0, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_ALLOC, 16'd0, 16'd1, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_ALLOC, 16'd0, 16'd999, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_SET_CLASS, 16'd2, 16'd0, LS_UNUSED, 3'd7, 7'd0);
    send_item(OP_SET_CLASS, 16'd2, 16'd0, LS_UNUSED, 3'd6, 7'd0);
    send_item(OP_SET_CLASS, 16'd2, 16'd0, LS_UNUSED, CL_SYSTEM, 7'd0);
    send_item(OP_SET_QUANT, 16'd1, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_SET_QUANT, 16'd1, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd65);
    send_item(OP_SET_QUANT, 16'hFFFF, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'h7F);
    send_item(OP_SET_QUANT, 16'd1, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd64);
    send_item(OP_SET_QUANT, 16'd3, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd1);
    send_item(OP_SET_STATE, 16'hFFFF, 16'd0, 3'd6, CL_INTERACTIVE, 7'd0);
    send_item(OP_SET_STATE, 16'd1, 16'd0, LS_RUNNABLE, CL_INTERACTIVE, 7'd0);
    send_item(OP_SET_STATE, 16'd2, 16'd0, LS_RUNNABLE, CL_INTERACTIVE, 7'd0);
    send_item(OP_SET_STATE, 16'd3, 16'd0, LS_SLEEPING, CL_INTERACTIVE, 7'd0);
    send_item(OP_TICK, 16'd0, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_PICK, 16'd0, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_TICK, 16'd0, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_QUERY, 16'd1, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_SET_STATE, 16'd3, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_QUERY, 16'd3, 16'd0, LS_UNUSED, CL_INTERACTIVE, 7'd0);
    send_item(OP_QUERY, 16'd0, 16'd0, LS_ZOMBIE, CL_INTERACTIVE, 7'd0);

    // Random phases under minimum, maximum and random register settings
    for (int ph = 0; ph < 3; ph++) begin
      reconfigure(ph);
      for (int n = 0; n < 625; n++) random_item(ph == 1 && n < 70);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (ITEM_CYCLES + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_replies.size() == 0)
      $display("priority_process_table_scheduler regression: pass");
    else
      $display("priority_process_table_scheduler regression: fail");
    $finish;
  end

endmodule
